@@ rtl/core/skt_pkg.sv @@
// Package for the sorted key table: table depth, field widths, operation and
// status codes, the command and result item types, and the cell control bus.
// No dependencies.
`default_nettype none

package skt_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 16;
    localparam int KEY_W       = 32;
    localparam int POS_W       = 4;
    localparam int CNT_W       = 5;

    typedef logic signed [KEY_W-1:0] key_t;

    // The most negative key is reserved and never stored.
    localparam key_t KEY_INVALID = {1'b1, {(KEY_W-1){1'b0}}};

    // Operation codes. The reserved code decodes as a read.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FULL      = 3'd4,
        ST_READ_OK   = 3'd5,
        ST_RANGE     = 3'd6
    } status_t;

    // One command item.
    typedef struct packed {
        logic [1:0]       op;
        key_t             key;
        logic [POS_W-1:0] position;
    } cmd_t;

    // One result item.
    typedef struct packed {
        status_t          status;
        key_t             read_key;
        logic [CNT_W-1:0] count;
    } result_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic ins_go;
        logic del_go;
        key_t key;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/skt_cell.sv @@
// One cell of the sorted key table: holds a single key, compares it with the
// broadcast key and shifts toward either neighbor on insert or delete.
// Depends on skt_pkg.
`default_nettype none

module skt_cell
    import skt_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire logic      valid,
    input  wire key_t      left_key,
    input  wire logic      left_open,
    input  wire key_t      right_key,
    output key_t           key_q,
    output logic           open,
    output logic           match
);

    key_t key_reg;
    key_t key_next;
    logic at_or_above;

    // The insert point is open here when this cell is empty or holds a larger key.
    assign open        = !valid || ($signed(ctl.key) < $signed(key_reg));
    assign match       = valid && (key_reg == ctl.key);
    assign at_or_above = valid && ($signed(key_reg) >= $signed(ctl.key));
    assign key_q       = key_reg;

    // An insert takes the left key past the insert point and the new key at it;
    // a delete pulls the right key into every cell from the first equal key on.
    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins_go)
        begin
            if (left_open)
            begin
                key_next = left_key;
            end
            else if (open)
            begin
                key_next = ctl.key;
            end
        end
        else if (ctl.del_go && at_or_above)
        begin
            key_next = right_key;
        end
    end

    // Key storage carries no reset; cells past the count are never read.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/sorted_key_table.sv @@
// Top level of the sorted key table: a row of key cells, the count register,
// the command decoder and the result register.
// Depends on skt_pkg and skt_cell.
//
//   Channel  Handshake          Payload   Direction
//   -------  -----------------  --------  ---------
//   command  start / busy       cmd       in
//   result   done (one cycle)   result    out
//
// Every item finishes in the cycle it is accepted: all cells compare and shift
// in parallel, so one item per clock is sustained and busy stays low.
// The result is registered and appears in the cycle after acceptance, marked by done for one cycle.
// Reset clears the count; the cell keys are not reset and are never read
// beyond the count. The receiver cannot stall the result.
`default_nettype none

module sorted_key_table
    import skt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      done,
    output result_t   result
);

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   done_reg;
    result_t                result_reg;
    result_t                result_next;

    cell_ctl_t              ctl;
    key_t                   keys [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] open_vec;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic                   key_ok;
    logic                   full;
    logic                   found;
    logic                   in_range;

    assign busy = 1'b0;

    // Row of cells; the first sees a closed left neighbor and the last its own key on the right.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        key_t left_key;
        logic left_open;
        key_t right_key;

        assign valid_vec[i] = count_reg > CNT_W'(i);

        if (i == 0)
        begin : g_first
            assign left_key  = '0;
            assign left_open = 1'b0;
        end
        else
        begin : g_inner
            assign left_key  = keys[i-1];
            assign left_open = open_vec[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign right_key = keys[i];
        end
        else
        begin : g_notlast
            assign right_key = keys[i+1];
        end

        skt_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .valid     (valid_vec[i]),
            .left_key  (left_key),
            .left_open (left_open),
            .right_key (right_key),
            .key_q     (keys[i]),
            .open      (open_vec[i]),
            .match     (match_vec[i])
        );
    end

    assign key_ok   = cmd.key != KEY_INVALID;
    assign full     = count_reg == CNT_W'(TABLE_DEPTH);
    assign found    = |match_vec;
    assign in_range = {1'b0, cmd.position} < count_reg;

    // Command decode: drive the cells, the next count and the result item.
    always_comb
    begin
        ctl.ins_go           = 1'b0;
        ctl.del_go           = 1'b0;
        ctl.key              = cmd.key;
        count_next           = count_reg;
        result_next.status   = ST_READ_OK;
        result_next.read_key = '0;
        unique case (cmd.op) inside
            OP_INSERT:
            begin
                if (!key_ok)
                begin
                    result_next.status = ST_INVALID;
                end
                else if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    result_next.status = ST_INSERTED;
                    ctl.ins_go         = start;
                    count_next         = count_reg + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (!key_ok)
                begin
                    result_next.status = ST_INVALID;
                end
                else if (found)
                begin
                    result_next.status = ST_DELETED;
                    ctl.del_go         = start;
                    count_next         = count_reg - 1'b1;
                end
                else
                begin
                    result_next.status = ST_NOT_FOUND;
                end
            end
            OP_READ, OP_RSVD:
            begin
                if (in_range)
                begin
                    result_next.status   = ST_READ_OK;
                    result_next.read_key = keys[cmd.position];
                end
                else
                begin
                    result_next.status = ST_RANGE;
                end
            end
            default:
            begin
                result_next.status = ST_RANGE;
            end
        endcase
        result_next.count = count_next;
    end

    // Control state: count and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted item yields exactly one result in the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done)
        else $error("result without an accepted item");

    // A successful insert grows the count by one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_INSERTED) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count");

    // The read key is zero on every status but a good read.
    a_read_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_READ_OK) |-> result.read_key == '0)
        else $error("read key not zero on a non-read result");

    // The count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("count above table depth");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_key_table: directed and random insert, delete and read items,
// each checked against a shadow copy of the sorted table kept here.
// Depends on skt_pkg and sorted_key_table.

module testbench;
    import skt_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1230;
    localparam int CALM_TAIL    = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 40;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    // Items waiting to be driven and results still owed by the block.
    cmd_t    queued_cmds[$];
    result_t awaited_results[$];

    // Shadow copy of the table contents and fill level.
    key_t    shadow_keys[TABLE_DEPTH];
    int      shadow_count = 0;

    int      mismatch_count = 0;
    int      idle_left = 0;
    logic    cmd_taken = 1'b0;
    int      random_added;
    int      run_left;
    int      insert_bias;
    int      pick;
    logic    [1:0] rand_op;
    result_t want;

    sorted_key_table uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Applies one command to the shadow table and returns the result it should give.
    function automatic result_t table_update(input cmd_t c);
        result_t r;
        int      slot;
        int      i;
        r.status   = ST_INSERTED;
        r.read_key = '0;
        if (c.op[1])
        begin
            // Both read codes: only the high bit of the operation matters.
            if (int'(c.position) < shadow_count)
            begin
                r.status   = ST_READ_OK;
                r.read_key = shadow_keys[c.position];
            end
            else
                r.status = ST_RANGE;
        end
        else if (c.key == KEY_INVALID)
            r.status = ST_INVALID;
        else if (c.op == OP_INSERT)
        begin
            if (shadow_count >= TABLE_DEPTH)
                r.status = ST_FULL;
            else
            begin
                // The new key goes in front of the first strictly larger key.
                slot = shadow_count;
                for (i = shadow_count - 1; i >= 0; i--)
                    if ($signed(c.key) < $signed(shadow_keys[i]))
                        slot = i;
                for (i = shadow_count; i > slot; i--)
                    shadow_keys[i] = shadow_keys[i - 1];
                shadow_keys[slot] = c.key;
                shadow_count++;
                r.status = ST_INSERTED;
            end
        end
        else
        begin
            // Delete removes the lowest-position equal key.
            slot = -1;
            for (i = shadow_count - 1; i >= 0; i--)
                if (shadow_keys[i] == c.key)
                    slot = i;
            if (slot < 0)
                r.status = ST_NOT_FOUND;
            else
            begin
                for (i = slot; i + 1 < shadow_count; i++)
                    shadow_keys[i] = shadow_keys[i + 1];
                shadow_count--;
                r.status = ST_DELETED;
            end
        end
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        if (mismatch_count < PRINT_LIMIT)
            $display("tb: mismatch at %0t: %s, got %h, expected %h", $realtime, what, got,
                     wanted);
        mismatch_count++;
    endtask

    task automatic add_cmd(input logic [1:0] op, input key_t key, input int unsigned pos);
        cmd_t item;
        item.op       = op;
        item.key      = key;
        item.position = pos[POS_W-1:0];
        queued_cmds.push_back(item);
    endtask

    // Mostly a small pool of keys so that duplicates and delete hits are common.
    function automatic key_t random_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return key_t'($urandom_range(0, 16)) - key_t'(8);
        else if (r < 62)
            return 32'sh7FFF_FFFF;
        else if (r < 68)
            return KEY_INVALID + key_t'(1);
        else if (r < 72)
            return KEY_INVALID;
        else
            return key_t'($urandom);
    endfunction

    // Driver: presents items at the falling edge, with random idle bursts.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            idle_left  = 0;
        end
        else if (start && !cmd_taken)
        begin
            // Item not yet accepted; hold it on the bus.
        end
        else if (idle_left > 0)
        begin
            idle_left--;
            start <= 1'b0;
        end
        else if (queued_cmds.size() == 0)
            start <= 1'b0;
        else if (queued_cmds.size() > CALM_TAIL && $urandom_range(0, 99) < 10)
        begin
            idle_left = $urandom_range(1, 14) - 1;
            start <= 1'b0;
        end
        else
        begin
            cmd   <= queued_cmds.pop_front();
            start <= 1'b1;
        end
    end

    // Acceptance and result check at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_taken    <= 1'b0;
            shadow_count  = 0;
        end
        else
        begin
            cmd_taken <= start && !busy;
            if (start && !busy)
                awaited_results.push_back(table_update(cmd));
            if (done)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch("result with no item waiting", 32'(result), 32'h0);
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(result.status), 32'(want.status));
                    if (result.read_key !== want.read_key)
                        report_mismatch("read_key", result.read_key, want.read_key);
                    if (result.count !== want.count)
                        report_mismatch("count", 32'(result.count), 32'(want.count));
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        // Empty table: reads out of range, delete misses, invalid keys rejected.
        add_cmd(OP_READ,   32'sd0, 0);
        add_cmd(OP_RSVD,   KEY_INVALID, 15);
        add_cmd(OP_DELETE, 32'sd5, 0);
        add_cmd(OP_INSERT, KEY_INVALID, 0);
        add_cmd(OP_DELETE, KEY_INVALID, 0);
        // Extreme keys and a duplicate.
        add_cmd(OP_INSERT, 32'sh7FFF_FFFF, 0);
        add_cmd(OP_INSERT, KEY_INVALID + key_t'(1), 0);
        add_cmd(OP_INSERT, 32'sd0, 0);
        add_cmd(OP_INSERT, 32'sd0, 0);
        add_cmd(OP_INSERT, -32'sd1, 0);
        // Reads ignore the key; the reserved code reads too.
        add_cmd(OP_READ,   KEY_INVALID, 0);
        add_cmd(OP_READ,   32'sh1234_5678, 4);
        add_cmd(OP_READ,   32'sd0, 5);
        add_cmd(OP_RSVD,   -32'sd1, 2);
        // Deletes: first of two equal keys, a miss, the largest key.
        add_cmd(OP_DELETE, 32'sd0, 0);
        add_cmd(OP_DELETE, 32'sd12345, 0);
        add_cmd(OP_DELETE, 32'sh7FFF_FFFF, 0);
        add_cmd(OP_READ,   32'sd0, 3);
        add_cmd(OP_READ,   32'sd0, 2);

        // Random part: fill bursts that reach a full table, and mixed runs that
        // lean toward inserts or toward deletes.
        random_added = 0;
        insert_bias  = 60;
        while (random_added < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                for (int i = 0; i < 18; i++)
                begin
                    pick = int'(random_key());
                    if (key_t'(pick) == KEY_INVALID)
                        pick = $urandom_range(0, 9);
                    add_cmd(OP_INSERT, key_t'(pick), 0);
                end
                add_cmd(OP_INSERT, KEY_INVALID, 0);
                add_cmd(OP_INSERT, random_key(), 0);
                for (int i = 0; i < 4; i++)
                    add_cmd(OP_READ, key_t'($urandom), $urandom_range(0, 15));
                random_added += 24;
            end
            else
            begin
                run_left    = $urandom_range(20, 50);
                insert_bias = (insert_bias == 60) ? 20 : 60;
                for (int i = 0; i < run_left; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < insert_bias)
                        rand_op = OP_INSERT;
                    else if (pick < 85)
                        rand_op = OP_DELETE;
                    else if (pick < 95)
                        rand_op = OP_READ;
                    else
                        rand_op = OP_RSVD;
                    add_cmd(rand_op, random_key(), $urandom_range(0, 15));
                end
                random_added += run_left;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        #(CLK_PERIOD / 4);
        rst_n = 1'b1;

        while (queued_cmds.size() != 0 || start)
            @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
